### rtl/hhp_pkg.sv
// ----------------------------------------------------------------------------
// hhp_pkg
// Shared types, constants and the microprogram of the heading-hold PID.
// ----------------------------------------------------------------------------
package hhp_pkg;

    // field widths
    localparam int RATE_W = 28;
    localparam int ANG_W  = 32;
    localparam int SUM_W  = 48;
    localparam int GAIN_W = 32;
    localparam int LIM_W  = 31;
    localparam int TERM_W = 40;
    localparam int STEP_W = 5;

    // register reset values
    localparam logic signed [ANG_W-1:0] SETPOINT_RST  = '0;
    localparam logic [GAIN_W-1:0]       GAIN_P_RST    = 32'd53687091;
    localparam logic [GAIN_W-1:0]       GAIN_I_RST    = 32'd2684;
    localparam logic [GAIN_W-1:0]       GAIN_D_RST    = 32'd563714457;
    localparam logic [GAIN_W-1:0]       TICK_RST      = 32'd4294967;
    localparam logic [LIM_W-1:0]        DEADBAND_RST  = 31'd6554;
    localparam logic [LIM_W-1:0]        INT_LIM_RST   = 31'd19661;
    localparam logic [LIM_W-1:0]        OUT_LIM_RST   = 31'd327680;

    // saturation bounds
    localparam logic signed [ANG_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ANG_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] S48_MIN = 48'sh8000_0000_0000;

    // register indexes
    typedef enum logic [2:0] {
        REG_SETPOINT,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_TICK,
        REG_DEADBAND,
        REG_INT_LIM,
        REG_OUT_LIM
    } t_reg;

    typedef struct packed {
        logic signed [ANG_W-1:0] setpoint;
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i;
        logic [GAIN_W-1:0]       gain_d;
        logic [GAIN_W-1:0]       tick;
        logic [LIM_W-1:0]        deadband;
        logic [LIM_W-1:0]        int_lim;
        logic [LIM_W-1:0]        out_lim;
    } t_cfg;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SRC,
        OP_MLO,
        OP_MHI,
        OP_MACC,
        OP_HEAD,
        OP_ERR,
        OP_TERM_P,
        OP_SUM,
        OP_TERM_I,
        OP_TERM_D,
        OP_OUT
    } t_op;

    // multiplier operand source
    typedef enum logic [1:0] {
        SRC_RATE,
        SRC_ERR,
        SRC_SUM,
        SRC_DIFF
    } t_src;

    // multiplier gain source
    typedef enum logic [1:0] {
        G_TICK,
        G_P,
        G_I,
        G_D
    } t_gsel;

    // step hold conditions
    typedef enum logic [1:0] {
        C_NONE,
        C_IN,
        C_OUT
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_src              src;
        t_gsel             gsel;
        logic              sh32;
        t_cond             cond;
        logic              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    // control handed to the datapath for the current step
    typedef struct packed {
        t_op   op;
        t_src  src;
        t_gsel gsel;
        logic  sh32;
        logic  fire;
    } t_ctrl;

    localparam logic [STEP_W-1:0] STEP_IDLE = '0;

    // microprogram rom
    function automatic t_uword urom(input logic [STEP_W-1:0] addr);
        t_uword w;
        w = '{op: OP_NOP, src: SRC_RATE, gsel: G_TICK, sh32: 1'b0,
              cond: C_NONE, jmp: 1'b0, target: STEP_IDLE};
        case (addr)
            5'd0: begin
                w.op   = OP_LOAD;
                w.cond = C_IN;
            end
            5'd1: begin
                w.op   = OP_SRC;
                w.src  = SRC_RATE;
                w.gsel = G_TICK;
                w.sh32 = 1'b1;
            end
            5'd2:  w.op = OP_MLO;
            5'd3:  w.op = OP_MHI;
            5'd4:  w.op = OP_MACC;
            5'd5:  w.op = OP_HEAD;
            5'd6:  w.op = OP_ERR;
            5'd7: begin
                w.op   = OP_SRC;
                w.src  = SRC_ERR;
                w.gsel = G_P;
            end
            5'd8:  w.op = OP_MLO;
            5'd9:  w.op = OP_MHI;
            5'd10: w.op = OP_MACC;
            5'd11: w.op = OP_TERM_P;
            5'd12: w.op = OP_SUM;
            5'd13: begin
                w.op   = OP_SRC;
                w.src  = SRC_SUM;
                w.gsel = G_I;
            end
            5'd14: w.op = OP_MLO;
            5'd15: w.op = OP_MHI;
            5'd16: w.op = OP_MACC;
            5'd17: w.op = OP_TERM_I;
            5'd18: begin
                w.op   = OP_SRC;
                w.src  = SRC_DIFF;
                w.gsel = G_D;
            end
            5'd19: w.op = OP_MLO;
            5'd20: w.op = OP_MHI;
            5'd21: w.op = OP_MACC;
            5'd22: w.op = OP_TERM_D;
            5'd23: begin
                w.op   = OP_OUT;
                w.cond = C_OUT;
                w.jmp  = 1'b1;
            end
            default: begin
                w.jmp = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/heading_hold_pid.sv
// ----------------------------------------------------------------------------
// heading_hold_pid
// Heading integrator followed by a positional PID, run by a microprogram.
// Items are handled one at a time by the 24-step microprogram, which runs
// four rounded products through the single 32x24 multiplier; a new item is
// taken only after the last one has been written to the output register.
// A new item is taken while the previous result waits in the output register.
// Reset (synchronous, active low) clears heading, error sum, last error and
// the output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module heading_hold_pid
    import hhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [27:0] yaw_rate, [31:28] zero
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] correction, [63:32] heading
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    t_cfg  r_cfg;
    t_ctrl w_ctrl;
    logic  w_out_free;
    logic  w_out_valid;
    logic signed [ANG_W-1:0] w_corr;
    logic signed [ANG_W-1:0] w_head;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint <= SETPOINT_RST;
            r_cfg.gain_p   <= GAIN_P_RST;
            r_cfg.gain_i   <= GAIN_I_RST;
            r_cfg.gain_d   <= GAIN_D_RST;
            r_cfg.tick     <= TICK_RST;
            r_cfg.deadband <= DEADBAND_RST;
            r_cfg.int_lim  <= INT_LIM_RST;
            r_cfg.out_lim  <= OUT_LIM_RST;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_addr))
                REG_SETPOINT: r_cfg.setpoint <= i_cfg_wdata;
                REG_GAIN_P:   r_cfg.gain_p   <= i_cfg_wdata;
                REG_GAIN_I:   r_cfg.gain_i   <= i_cfg_wdata;
                REG_GAIN_D:   r_cfg.gain_d   <= i_cfg_wdata;
                REG_TICK:     r_cfg.tick     <= i_cfg_wdata;
                REG_DEADBAND: r_cfg.deadband <= i_cfg_wdata[LIM_W-1:0];
                REG_INT_LIM:  r_cfg.int_lim  <= i_cfg_wdata[LIM_W-1:0];
                REG_OUT_LIM:  r_cfg.out_lim  <= i_cfg_wdata[LIM_W-1:0];
                default:      ;
            endcase
        end
    end

    // sequencer
    hhp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    // datapath
    hhp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_cfg        (r_cfg),
        .i_rate       (s_axis_tdata[RATE_W-1:0]),
        .i_out_ready  (m_axis_tready),
        .o_out_free   (w_out_free),
        .o_out_valid  (w_out_valid),
        .o_correction (w_corr),
        .o_heading    (w_head)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {w_head, w_corr};

endmodule

### rtl/hhp_seq.sv
// ----------------------------------------------------------------------------
// hhp_seq
// Step counter and microprogram fetch; holds a step until its condition is met.
// ----------------------------------------------------------------------------
module hhp_seq
    import hhp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w_word;
    logic              w_go;

    // fetch and condition check
    always_comb begin
        w_word = urom(r_step);
        case (w_word.cond)
            C_NONE:  w_go = 1'b1;
            C_IN:    w_go = i_in_valid;
            C_OUT:   w_go = i_out_free;
            default: w_go = 1'b0;
        endcase
    end

    // next step: hold, advance or jump
    always_comb begin
        if (!w_go) begin
            n_step = r_step;
        end else if (w_word.jmp) begin
            n_step = w_word.target;
        end else begin
            n_step = r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // control to the datapath
    assign o_in_ready   = (w_word.cond == C_IN);
    assign o_ctrl.op    = w_word.op;
    assign o_ctrl.src   = w_word.src;
    assign o_ctrl.gsel  = w_word.gsel;
    assign o_ctrl.sh32  = w_word.sh32;
    assign o_ctrl.fire  = w_go;

endmodule

### rtl/hhp_dp.sv
// ----------------------------------------------------------------------------
// hhp_dp
// Datapath: shared 32x24 multiplier with rounding accumulator, controller
// state, term registers and the output register.
// ----------------------------------------------------------------------------
module hhp_dp
    import hhp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    input  t_cfg                     i_cfg,
    input  logic signed [RATE_W-1:0] i_rate,
    input  logic                     i_out_ready,
    output logic                     o_out_free,
    output logic                     o_out_valid,
    output logic signed [ANG_W-1:0]  o_correction,
    output logic signed [ANG_W-1:0]  o_heading
);

    // controller state
    logic signed [ANG_W-1:0]  r_heading;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [ANG_W-1:0]  r_last;
    logic signed [ANG_W-1:0]  r_err;
    logic signed [RATE_W-1:0] r_rate;

    // multiplier working registers
    logic [GAIN_W-1:0] r_gain;
    logic [47:0]       r_mag;
    logic              r_neg;
    logic              r_sh32;
    logic [55:0]       r_prod;
    logic [80:0]       r_acc;

    // terms
    logic signed [TERM_W-1:0] r_p;
    logic signed [TERM_W-1:0] r_d;
    logic signed [ANG_W-1:0]  r_i;

    // output register
    logic                    r_out_valid;
    logic signed [ANG_W-1:0] r_out_corr;
    logic signed [ANG_W-1:0] r_out_head;

    logic signed [48:0] w_opnd;
    logic signed [48:0] w_opnd_abs;
    logic [GAIN_W-1:0]  w_gain;
    logic [23:0]        w_mul_in;
    logic [55:0]        w_mlt;
    logic [80:0]        w_half;
    logic [52:0]        w_res_mag;
    logic signed [53:0] w_res;
    logic signed [54:0] w_hd;
    logic signed [ANG_W-1:0] n_heading;
    logic signed [32:0] w_e33;
    logic [32:0]        w_emag;
    logic signed [ANG_W-1:0] n_err;
    logic signed [48:0] w_s49;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [53:0] w_ilim;
    logic signed [ANG_W-1:0] n_i;
    logic signed [41:0] w_tot;
    logic signed [41:0] w_olim;
    logic signed [ANG_W-1:0] n_corr;

    // multiplier operand and its magnitude
    always_comb begin
        case (i_ctrl.src)
            SRC_RATE: w_opnd = 49'(r_rate);
            SRC_ERR:  w_opnd = 49'(r_err);
            SRC_SUM:  w_opnd = 49'(r_sum);
            SRC_DIFF: w_opnd = 49'(r_err) - 49'(r_last);
            default:  w_opnd = '0;
        endcase
        w_opnd_abs = w_opnd[48] ? -w_opnd : w_opnd;
    end

    // gain select
    always_comb begin
        case (i_ctrl.gsel)
            G_TICK:  w_gain = i_cfg.tick;
            G_P:     w_gain = i_cfg.gain_p;
            G_I:     w_gain = i_cfg.gain_i;
            G_D:     w_gain = i_cfg.gain_d;
            default: w_gain = '0;
        endcase
    end

    // shared multiplier, low digit then high digit
    assign w_mul_in = (i_ctrl.op == OP_MHI) ? r_mag[47:24] : r_mag[23:0];
    assign w_mlt    = r_gain * w_mul_in;
    assign w_half   = r_sh32 ? (81'd1 << 31) : (81'd1 << 27);

    // rounded signed product
    always_comb begin
        w_res_mag = r_sh32 ? 53'(r_acc[80:32]) : r_acc[80:28];
        w_res     = r_neg ? -$signed({1'b0, w_res_mag}) : $signed({1'b0, w_res_mag});
    end

    // heading update with saturation
    always_comb begin
        w_hd = 55'(r_heading) - 55'(w_res);
        if (w_hd > 55'(S32_MAX)) begin
            n_heading = S32_MAX;
        end else if (w_hd < 55'(S32_MIN)) begin
            n_heading = S32_MIN;
        end else begin
            n_heading = w_hd[31:0];
        end
    end

    // error with deadband on the exact difference, then saturation
    always_comb begin
        w_e33  = 33'(i_cfg.setpoint) - 33'(r_heading);
        w_emag = w_e33[32] ? 33'(-w_e33) : 33'(w_e33);
        if (w_emag < {2'b00, i_cfg.deadband}) begin
            n_err = '0;
        end else if (w_e33 > 33'(S32_MAX)) begin
            n_err = S32_MAX;
        end else if (w_e33 < 33'(S32_MIN)) begin
            n_err = S32_MIN;
        end else begin
            n_err = w_e33[31:0];
        end
    end

    // error sum with 48-bit saturation
    always_comb begin
        w_s49 = 49'(r_sum) + 49'(r_err);
        if (w_s49 > 49'(S48_MAX)) begin
            n_sum = S48_MAX;
        end else if (w_s49 < 49'(S48_MIN)) begin
            n_sum = S48_MIN;
        end else begin
            n_sum = w_s49[47:0];
        end
    end

    // integral term clamp
    always_comb begin
        w_ilim = $signed({23'd0, i_cfg.int_lim});
        if (w_res > w_ilim) begin
            n_i = w_ilim[31:0];
        end else if (w_res < -w_ilim) begin
            n_i = 32'(-w_ilim);
        end else begin
            n_i = w_res[31:0];
        end
    end

    // output sum and clamp
    always_comb begin
        w_tot  = 42'(r_p) + 42'(r_i) + 42'(r_d);
        w_olim = $signed({11'd0, i_cfg.out_lim});
        if (w_tot > w_olim) begin
            n_corr = w_olim[31:0];
        end else if (w_tot < -w_olim) begin
            n_corr = 32'(-w_olim);
        end else begin
            n_corr = w_tot[31:0];
        end
    end

    assign o_out_free = !r_out_valid || i_out_ready;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_sum     <= '0;
            r_last    <= '0;
        end else if (i_ctrl.fire) begin
            case (i_ctrl.op)
                OP_HEAD:   r_heading <= n_heading;
                OP_SUM:    r_sum     <= n_sum;
                OP_TERM_D: r_last    <= r_err;
                default:   ;
            endcase
        end
    end

    // working registers and terms
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            case (i_ctrl.op)
                OP_LOAD:   r_rate <= i_rate;
                OP_SRC: begin
                    r_mag  <= w_opnd_abs[47:0];
                    r_neg  <= w_opnd[48];
                    r_gain <= w_gain;
                    r_sh32 <= i_ctrl.sh32;
                end
                OP_MLO:    r_prod <= w_mlt;
                OP_MHI: begin
                    r_acc  <= {25'd0, r_prod} + w_half;
                    r_prod <= w_mlt;
                end
                OP_MACC:   r_acc <= r_acc + {1'b0, r_prod, 24'd0};
                OP_ERR:    r_err <= n_err;
                OP_TERM_P: r_p   <= w_res[TERM_W-1:0];
                OP_TERM_I: r_i   <= n_i;
                OP_TERM_D: r_d   <= w_res[TERM_W-1:0];
                default:   ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.fire && i_ctrl.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire && i_ctrl.op == OP_OUT) begin
            r_out_corr <= n_corr;
            r_out_head <= r_heading;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_correction = r_out_corr;
    assign o_heading    = r_out_head;

endmodule
